FILE: src/bis_pkg.sv
// bis_pkg: shared types and constants of the bilinear image scaler
// no dependencies
package bis_pkg;

  localparam int COORD_W   = 10;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int SRC_CFG_W = 9;
  localparam int DST_CFG_W = 11;
  localparam int CFG_ADDR_W = 4;

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_REQ  = 1'b1;

  localparam logic [SRC_CFG_W-1:0] SRC_RESET = SRC_CFG_W'(256);
  localparam logic [DST_CFG_W-1:0] DST_RESET = DST_CFG_W'(256);

  typedef struct packed {
    logic               mode;
    logic               oor;
    logic               ld_ok;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   rgb;
  } entry_t;

endpackage

FILE: src/bis_ram.sv
// bis_ram: generic single-port ram, registered read
// no dependencies
module bis_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

FILE: src/bis_front.sv
// bis_front: accepts items, classifies them and queues them for the back end
// depends on bis_pkg
module bis_front #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic                             in_mode,
  input  logic [bis_pkg::COORD_W-1:0]      in_coord_x,
  input  logic [bis_pkg::COORD_W-1:0]      in_coord_y,
  input  logic [bis_pkg::CH_W-1:0]         in_red,
  input  logic [bis_pkg::CH_W-1:0]         in_green,
  input  logic [bis_pkg::CH_W-1:0]         in_blue,
  input  logic [bis_pkg::DST_CFG_W-1:0]    dst_width,
  input  logic [bis_pkg::DST_CFG_W-1:0]    dst_height,
  output logic                             q_valid,
  output bis_pkg::entry_t                  q_entry,
  input  logic                             q_pop
);
  import bis_pkg::*;

  entry_t           mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  entry_t           ent;
  logic [DST_CFG_W-1:0] dw, dh;
  logic             do_push;

  always_comb begin
    dw = (dst_width == '0) ? DST_CFG_W'(1) : dst_width;
    dh = (dst_height == '0) ? DST_CFG_W'(1) : dst_height;
    ent.mode  = in_mode;
    ent.oor   = (DST_CFG_W'(in_coord_x) >= dw) || (DST_CFG_W'(in_coord_y) >= dh);
    ent.ld_ok = (32'(in_coord_x) < 32'(MAX_SRC_WIDTH)) &&
                (32'(in_coord_y) < 32'(MAX_SRC_HEIGHT));
    ent.x     = in_coord_x;
    ent.y     = in_coord_y;
    ent.rgb   = {in_red, in_green, in_blue};
  end

  assign full    = (cnt_r == 2'd2);
  assign do_push = push && !full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_entry = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(q_pop);
    end
  end

endmodule

FILE: src/bis_div.sv
// bis_div: restoring divider, one quotient bit per cycle
// no dependencies
module bis_div #(
  parameter int N = 27,
  parameter int D = 11
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dvd,
  input  logic [D-1:0] dvs,
  output logic         busy,
  output logic [N-1:0] quo
);

  logic [N-1:0]         q_r;
  logic [D-1:0]         rem_r;
  logic [D-1:0]         dvs_r;
  logic [$clog2(N+1)-1:0] cnt_r;
  logic                 busy_r;
  logic [D:0]           t;
  logic                 ge;

  always_comb begin
    t  = {rem_r, q_r[N-1]};
    ge = (t >= {1'b0, dvs_r});
  end

  assign busy = busy_r;
  assign quo  = q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dvd;
      rem_r <= '0;
      dvs_r <= dvs;
    end else if (busy_r) begin
      q_r   <= {q_r[N-2:0], ge};
      rem_r <= ge ? D'(t - {1'b0, dvs_r}) : t[D-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= ($clog2(N+1))'(N);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == ($clog2(N+1))'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

FILE: src/bis_back.sv
// bis_back: executes loads and requests, owns the frame store and the result register
// depends on bis_pkg, bis_div, bis_ram
module bis_back #(
  parameter int MAX_SRC_WIDTH    = 256,
  parameter int MAX_SRC_HEIGHT   = 256,
  parameter int WEIGHT_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  bis_pkg::entry_t               q_entry,
  output logic                          q_pop,
  input  logic [bis_pkg::SRC_CFG_W-1:0] src_width,
  input  logic [bis_pkg::SRC_CFG_W-1:0] src_height,
  input  logic [bis_pkg::DST_CFG_W-1:0] dst_width,
  input  logic [bis_pkg::DST_CFG_W-1:0] dst_height,
  output logic                          empty,
  input  logic                          pop,
  output logic [bis_pkg::CH_W-1:0]      out_red,
  output logic [bis_pkg::CH_W-1:0]      out_green,
  output logic [bis_pkg::CH_W-1:0]      out_blue,
  output logic [bis_pkg::COORD_W-1:0]   out_x,
  output logic [bis_pkg::COORD_W-1:0]   out_y,
  output logic                          out_of_range
);
  import bis_pkg::*;

  localparam int F    = WEIGHT_FRAC_BITS;
  localparam int SWW  = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SHW  = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int XW   = $clog2(MAX_SRC_WIDTH);
  localparam int YW   = $clog2(MAX_SRC_HEIGHT);
  localparam int IXW  = COORD_W + SWW;
  localparam int IYW  = COORD_W + SHW;
  localparam int NX   = IXW + F;
  localparam int NY   = IYW + F;
  localparam int AW   = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
  localparam int WW   = 2 * F + 1;
  localparam int PW   = WW + CH_W;
  localparam int SUMW = PW + 2;
  localparam logic [AW-1:0] ROW_A = AW'(MAX_SRC_WIDTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_WGT  = 5'b00100,
    S_RD   = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [SWW-1:0] sw, smx;
  logic [SHW-1:0] sh, smy;
  logic [DST_CFG_W-1:0] dw, dh;

  logic [COORD_W-1:0] x_r, y_r;
  logic               div_start, busy_x, busy_y;
  logic [NX-1:0]      quo_x;
  logic [NY-1:0]      quo_y;
  logic [IXW-1:0]     ix, ixc;
  logic [IYW-1:0]     iy, iyc;
  logic [SWW-1:0]     x0p1;
  logic [SHW-1:0]     y0p1;
  logic [XW-1:0]      x0, x1, x0_r, x1_r;
  logic [YW-1:0]      y0, y1, y0_r, y1_r;
  logic [F:0]         fx, fy, ofx, ofy;
  logic [WW-1:0]      w_r [4];
  logic [2:0]         step_r;
  logic [1:0]         kk;
  logic [PW-1:0]      prod_r [3];
  logic [SUMW-1:0]    acc_r [3];

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [PIX_W-1:0]   rdata;
  logic [XW-1:0]      rx;
  logic [YW-1:0]      ry;

  logic               out_free, res_ld, res_oor;
  logic               out_valid_r;
  logic               req_ok, oor_go;

  always_comb begin
    if (src_width == '0) begin
      sw = SWW'(1);
    end else if (32'(src_width) > 32'(MAX_SRC_WIDTH)) begin
      sw = SWW'(MAX_SRC_WIDTH);
    end else begin
      sw = SWW'(src_width);
    end
    if (src_height == '0) begin
      sh = SHW'(1);
    end else if (32'(src_height) > 32'(MAX_SRC_HEIGHT)) begin
      sh = SHW'(MAX_SRC_HEIGHT);
    end else begin
      sh = SHW'(src_height);
    end
    dw  = (dst_width == '0) ? DST_CFG_W'(1) : dst_width;
    dh  = (dst_height == '0) ? DST_CFG_W'(1) : dst_height;
    smx = sw - 1'b1;
    smy = sh - 1'b1;
  end

  assign out_free = !out_valid_r || pop;
  assign req_ok   = (state_r == S_IDLE) && q_valid && (q_entry.mode == MODE_REQ)
                    && !q_entry.oor;
  assign oor_go   = (state_r == S_IDLE) && q_valid && (q_entry.mode == MODE_REQ)
                    && q_entry.oor && out_free;
  assign div_start = req_ok;
  assign q_pop = (state_r == S_IDLE) && q_valid &&
                 ((q_entry.mode == MODE_LOAD) || !q_entry.oor || out_free);
  assign ram_we = (state_r == S_IDLE) && q_valid && (q_entry.mode == MODE_LOAD)
                  && q_entry.ld_ok;
  assign res_ld  = oor_go || ((state_r == S_DONE) && out_free);
  assign res_oor = oor_go;

  bis_div #(.N(NX), .D(DST_CFG_W)) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   ({IXW'(q_entry.x) * IXW'(sw), {F{1'b0}}}),
    .dvs   (dw),
    .busy  (busy_x),
    .quo   (quo_x)
  );

  bis_div #(.N(NY), .D(DST_CFG_W)) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   ({IYW'(q_entry.y) * IYW'(sh), {F{1'b0}}}),
    .dvs   (dh),
    .busy  (busy_y),
    .quo   (quo_y)
  );

  // index clamp and fractional weights
  always_comb begin
    ix   = quo_x[NX-1:F];
    iy   = quo_y[NY-1:F];
    ixc  = (ix > IXW'(smx)) ? IXW'(smx) : ix;
    iyc  = (iy > IYW'(smy)) ? IYW'(smy) : iy;
    x0   = XW'(ixc);
    y0   = YW'(iyc);
    x0p1 = SWW'(x0) + 1'b1;
    y0p1 = SHW'(y0) + 1'b1;
    x1   = (x0p1 < sw) ? XW'(x0p1) : XW'(smx);
    y1   = (y0p1 < sh) ? YW'(y0p1) : YW'(smy);
    fx   = {1'b0, quo_x[F-1:0]};
    fy   = {1'b0, quo_y[F-1:0]};
    ofx  = (F+1)'(1 << F) - fx;
    ofy  = (F+1)'(1 << F) - fy;
  end

  always_comb begin
    rx = step_r[0] ? x1_r : x0_r;
    ry = step_r[1] ? y1_r : y0_r;
    kk = 2'(step_r - 3'd1);
    if (state_r == S_RD) begin
      ram_addr = AW'(ry) * ROW_A + AW'(rx);
    end else begin
      ram_addr = AW'(YW'(q_entry.y)) * ROW_A + AW'(XW'(q_entry.x));
    end
  end

  bis_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SRC_WIDTH * MAX_SRC_HEIGHT)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (q_entry.rgb),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (req_ok) state_nxt = S_DIV;
      S_DIV:  if (!busy_x && !busy_y) state_nxt = S_WGT;
      S_WGT:  state_nxt = S_RD;
      S_RD:   if (step_r == 3'd5) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_ok) begin
      x_r <= q_entry.x;
      y_r <= q_entry.y;
    end
    if (state_r == S_WGT) begin
      x0_r   <= x0;
      x1_r   <= x1;
      y0_r   <= y0;
      y1_r   <= y1;
      w_r[0] <= WW'(ofx * ofy);
      w_r[1] <= WW'(fx * ofy);
      w_r[2] <= WW'(ofx * fy);
      w_r[3] <= WW'(fx * fy);
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= '0;
      end
    end
    if (state_r == S_RD) begin
      if (step_r >= 3'd1 && step_r <= 3'd4) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[c] <= PW'(w_r[kk] * rdata[(2-c)*CH_W +: CH_W]);
        end
      end
      if (step_r >= 3'd2) begin
        for (int c = 0; c < 3; c++) begin
          acc_r[c] <= acc_r[c] + SUMW'(prod_r[c]);
        end
      end
    end
    if (res_ld) begin
      if (res_oor) begin
        out_red   <= '0;
        out_green <= '0;
        out_blue  <= '0;
        out_x     <= q_entry.x;
        out_y     <= q_entry.y;
      end else begin
        out_red   <= acc_r[0][2*F +: CH_W];
        out_green <= acc_r[1][2*F +: CH_W];
        out_blue  <= acc_r[2][2*F +: CH_W];
        out_x     <= x_r;
        out_y     <= y_r;
      end
      out_of_range <= res_oor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_RD) begin
        step_r <= step_r + 3'd1;
      end else begin
        step_r <= '0;
      end
      if (res_ld) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign empty = !out_valid_r;

endmodule

FILE: src/bilinear_image_scaler.sv
// bilinear_image_scaler: top level, configuration registers, front and back ends
// depends on bis_pkg, bis_front, bis_back
//
//   channel   handshake              payload
//   input     push / full            in_mode in_coord_x in_coord_y in_red in_green in_blue
//   result    pop / empty            out_red out_green out_blue out_x out_y out_of_range
//   config    psel penable pwrite    paddr pwdata prdata pready
//
// the back end writes an in-bounds load to the frame store as it pops it; an out-of-range
// request loads the result register as it is popped, once that register is free; an
// in-range request goes through the bit-serial position dividers, the weight step and four
// frame store reads through the single ram port before its result is registered
// the two-entry queue accepts until full while the back end works or a result waits
// synchronous active-low reset; frame store contents are undefined until loaded
module bilinear_image_scaler #(
  parameter int MAX_SRC_WIDTH    = 256,
  parameter int MAX_SRC_HEIGHT   = 256,
  parameter int WEIGHT_FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic                           in_mode,
  input  logic [bis_pkg::COORD_W-1:0]    in_coord_x,
  input  logic [bis_pkg::COORD_W-1:0]    in_coord_y,
  input  logic [bis_pkg::CH_W-1:0]       in_red,
  input  logic [bis_pkg::CH_W-1:0]       in_green,
  input  logic [bis_pkg::CH_W-1:0]       in_blue,
  output logic                           empty,
  input  logic                           pop,
  output logic [bis_pkg::CH_W-1:0]       out_red,
  output logic [bis_pkg::CH_W-1:0]       out_green,
  output logic [bis_pkg::CH_W-1:0]       out_blue,
  output logic [bis_pkg::COORD_W-1:0]    out_x,
  output logic [bis_pkg::COORD_W-1:0]    out_y,
  output logic                           out_of_range,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bis_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import bis_pkg::*;

  logic [SRC_CFG_W-1:0] src_width_r, src_height_r;
  logic [DST_CFG_W-1:0] dst_width_r, dst_height_r;
  logic                 cfg_wr;
  logic [1:0]           cfg_idx;
  logic                 q_valid, q_pop;
  entry_t               q_entry;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_RESET;
      src_height_r <= SRC_RESET;
      dst_width_r  <= DST_RESET;
      dst_height_r <= DST_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SRC_WIDTH:  src_width_r  <= pwdata[SRC_CFG_W-1:0];
        REG_SRC_HEIGHT: src_height_r <= pwdata[SRC_CFG_W-1:0];
        REG_DST_WIDTH:  dst_width_r  <= pwdata[DST_CFG_W-1:0];
        REG_DST_HEIGHT: dst_height_r <= pwdata[DST_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SRC_WIDTH:  prdata = 32'(src_width_r);
      REG_SRC_HEIGHT: prdata = 32'(src_height_r);
      REG_DST_WIDTH:  prdata = 32'(dst_width_r);
      REG_DST_HEIGHT: prdata = 32'(dst_height_r);
      default:        prdata = '0;
    endcase
  end

  bis_front #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_mode    (in_mode),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .dst_width  (dst_width_r),
    .dst_height (dst_height_r),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop)
  );

  bis_back #(
    .MAX_SRC_WIDTH    (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT   (MAX_SRC_HEIGHT),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop),
    .src_width    (src_width_r),
    .src_height   (src_height_r),
    .dst_width    (dst_width_r),
    .dst_height   (dst_height_r),
    .empty        (empty),
    .pop          (pop),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_of_range (out_of_range)
  );

endmodule

FILE: test/bilinear_image_scaler_tb.sv
// bilinear_image_scaler_tb: self-checking testbench of the bilinear image scaler
// depends on bis_pkg and bilinear_image_scaler; predicts each resized pixel and checks results
module bilinear_image_scaler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bis_pkg::*;

  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CH_W-1:0]    r;
    logic [CH_W-1:0]    g;
    logic [CH_W-1:0]    b;
  } pix_item_t;

  typedef struct packed {
    logic [CH_W-1:0]    r;
    logic [CH_W-1:0]    g;
    logic [CH_W-1:0]    b;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               oor;
  } pix_result_t;

  localparam int MAXW = 256;
  localparam int MAXH = 256;
  localparam int FRAC = 8;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full, empty;
  logic pop = 1'b0;
  logic in_mode = 1'b0;
  logic [COORD_W-1:0] in_coord_x = '0, in_coord_y = '0;
  logic [CH_W-1:0] in_red = '0, in_green = '0, in_blue = '0;
  logic [CH_W-1:0] out_red, out_green, out_blue;
  logic [COORD_W-1:0] out_x, out_y;
  logic out_of_range;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bilinear_image_scaler u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pix_item_t pending_items[$];
  pix_result_t expected_pixels[$];
  logic [PIX_W-1:0] shadow_store[int];
  int src_w = 256, src_h = 256, dst_w = 256, dst_h = 256;
  int mismatches = 0, requests_checked = 0, loads_sent = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;
  bit hold_off_req = 1'b0;
  bit timed_out = 1'b0;

  function automatic int eff_size(int v, int maxv);
    if (v == 0) return 1;
    return v > maxv ? maxv : v;
  endfunction

  function automatic pix_result_t scale_pixel(pix_item_t it);
    pix_result_t res;
    int sw, sh, dw, dh, numx, numy, x0, x1, y0, y1, fx, fy, sx, sy;
    longint wt[4], acc;
    logic [PIX_W-1:0] nb[4];
    sw = eff_size(src_w, MAXW);
    sh = eff_size(src_h, MAXH);
    dw = eff_size(dst_w, 2047);
    dh = eff_size(dst_h, 2047);
    res = '0;
    res.x = it.x;
    res.y = it.y;
    if (it.x >= dw || it.y >= dh) begin
      res.oor = 1'b1;
      return res;
    end
    numx = it.x * sw;
    numy = it.y * sh;
    x0 = numx / dw;
    y0 = numy / dh;
    fx = ((numx % dw) << FRAC) / dw;
    fy = ((numy % dh) << FRAC) / dh;
    if (x0 > sw - 1) x0 = sw - 1;
    if (y0 > sh - 1) y0 = sh - 1;
    x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
    y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
    nb[0] = shadow_store.exists(y0 * MAXW + x0) ? shadow_store[y0 * MAXW + x0] : '0;
    nb[1] = shadow_store.exists(y0 * MAXW + x1) ? shadow_store[y0 * MAXW + x1] : '0;
    nb[2] = shadow_store.exists(y1 * MAXW + x0) ? shadow_store[y1 * MAXW + x0] : '0;
    nb[3] = shadow_store.exists(y1 * MAXW + x1) ? shadow_store[y1 * MAXW + x1] : '0;
    sx = (1 << FRAC) - fx;
    sy = (1 << FRAC) - fy;
    wt[0] = sx * sy;
    wt[1] = fx * sy;
    wt[2] = sx * fy;
    wt[3] = fx * fy;
    for (int c = 0; c < 3; c++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) acc += wt[k] * ((nb[k] >> (16 - 8 * c)) & 8'hff);
      acc = (acc >> (2 * FRAC)) & 8'hff;
      if (c == 0) res.r = acc[7:0];
      else if (c == 1) res.g = acc[7:0];
      else res.b = acc[7:0];
    end
    return res;
  endfunction

  // sample of handshake at the rising edge for the driver
  logic full_at_edge = 1'b0;
  always @(posedge clk) full_at_edge <= full;

  // driver
  int push_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (push && !full_at_edge) begin
        void'(pending_items.pop_front());
      end
      if (push_gap > 0) begin
        push_gap <= push_gap - 1;
        push <= 1'b0;
      end else if (pending_items.size() > 0 && !(push && !full_at_edge && gaps_on &&
                   $urandom_range(0, 9) == 0)) begin
        push <= 1'b1;
        {in_mode, in_coord_x, in_coord_y, in_red, in_green, in_blue} <= pending_items[0];
      end else begin
        push <= 1'b0;
        if (gaps_on && pending_items.size() > 0) push_gap <= $urandom_range(0, 7);
      end
    end
  end

  // prediction at acceptance
  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      if (in_mode == MODE_LOAD) begin
        loads_sent++;
        if (in_coord_x < MAXW && in_coord_y < MAXH)
          shadow_store[in_coord_y * MAXW + in_coord_x] = {in_red, in_green, in_blue};
      end else begin
        expected_pixels.push_back(scale_pixel({in_mode, in_coord_x, in_coord_y,
                                               in_red, in_green, in_blue}));
      end
    end
  end

  // receiver
  int pop_gap = 0;
  int hold_count = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off_req && hold_count < 600) begin
        hold_count <= hold_count + 1;
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap <= pop_gap - 1;
        pop <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        pop_gap <= $urandom_range(0, 7);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // monitor
  pix_result_t got, want;
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      got = {out_red, out_green, out_blue, out_x, out_y, out_of_range};
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_pixels.pop_front();
        requests_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch at (%0d,%0d): expected %p actual %p",
                                         want.x, want.y, want, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("[bilinear_image_scaler] ERROR");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, int value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(idx) << 2;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SRC_WIDTH: src_w = value & 9'h1ff;
      REG_SRC_HEIGHT: src_h = value & 9'h1ff;
      REG_DST_WIDTH: dst_w = value & 11'h7ff;
      default: dst_h = value & 11'h7ff;
    endcase
  endtask

  task automatic drain;
    wait (pending_items.size() == 0 && !push);
    wait (expected_pixels.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_sizes(int sw, int sh, int dw, int dh);
    drain();
    cfg_write(REG_SRC_WIDTH, sw);
    cfg_write(REG_SRC_HEIGHT, sh);
    cfg_write(REG_DST_WIDTH, dw);
    cfg_write(REG_DST_HEIGHT, dh);
  endtask

  function automatic void add_item(logic mode, int x, int y, logic [PIX_W-1:0] rgb);
    pending_items.push_back({mode, COORD_W'(x), COORD_W'(y), rgb});
  endfunction

  // loads the whole visible source so no request reads an unwritten entry
  function automatic void fill_source(int sw, int sh, int pattern);
    for (int y = 0; y < eff_size(sh, MAXH); y++)
      for (int x = 0; x < eff_size(sw, MAXW); x++)
        add_item(MODE_LOAD, x, y, pattern == 0 ? 24'h0 :
                 pattern == 1 ? 24'hffffff : PIX_W'($urandom));
  endfunction

  function automatic void random_requests(int n, int dw, int dh);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        add_item(MODE_REQ, $urandom_range(0, 1023), $urandom_range(0, 1023), PIX_W'($urandom));
      else
        add_item(MODE_REQ, $urandom_range(0, eff_size(dw, 2047) - 1) % 1024,
                 $urandom_range(0, eff_size(dh, 2047) - 1) % 1024, PIX_W'($urandom));
    end
  endfunction

  initial begin
    int sw, sh, dw, dh;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: small source, extremes, edges and ignored loads
    set_sizes(2, 2, 4, 4);
    fill_source(2, 2, 1);
    add_item(MODE_REQ, 0, 0, '0);
    add_item(MODE_REQ, 3, 3, '0);
    add_item(MODE_REQ, 4, 0, '0);
    add_item(MODE_REQ, 1023, 1023, 24'hffffff);
    add_item(MODE_LOAD, 1023, 5, 24'h123456);
    add_item(MODE_LOAD, 5, 1023, 24'h654321);
    add_item(MODE_LOAD, 300, 0, 24'hffffff);
    add_item(MODE_LOAD, 0, 0, 24'h000000);
    add_item(MODE_LOAD, 1, 1, 24'hffffff);
    add_item(MODE_LOAD, 1, 0, 24'hff00ff);
    for (int i = 0; i < 4; i++) add_item(MODE_REQ, i, i ^ 1, '0);
    set_sizes(0, 0, 0, 0);
    add_item(MODE_REQ, 0, 0, '0);
    add_item(MODE_REQ, 1, 0, '0);
    set_sizes(511, 511, 2047, 2047);
    fill_source(256, 3, 2);
    add_item(MODE_REQ, 1023, 0, '0);
    add_item(MODE_REQ, 511, 1, '0);
    add_item(MODE_REQ, 0, 2, '0);
    set_sizes(256, 256, 1, 1);
    add_item(MODE_REQ, 0, 0, '0);
    add_item(MODE_REQ, 0, 1, '0);

    // long receiver hold-off while requests keep coming
    set_sizes(3, 3, 1024, 1024);
    fill_source(3, 3, 2);
    hold_off_req = 1'b1;
    random_requests(40, 1024, 1024);
    drain();
    hold_off_req = 1'b0;

    // random phases over several size settings
    for (int ph = 0; ph < 8; ph++) begin
      sw = $urandom_range(1, 16);
      sh = $urandom_range(1, 16);
      dw = (ph == 0) ? 1024 : $urandom_range(1, 64);
      dh = (ph == 1) ? 1024 : $urandom_range(1, 64);
      if (ph == 7) gaps_on = 1'b0;
      set_sizes(sw, sh, dw, dh);
      fill_source(sw, sh, 2);
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(0, 4) == 0)
          add_item(MODE_LOAD, $urandom_range(0, sw - 1), $urandom_range(0, sh - 1),
                   PIX_W'($urandom));
        else random_requests(1, dw, dh);
      end
    end
    drain();

    $display("checked %0d scaled pixels from %0d pixel loads over several size settings",
             requests_checked, loads_sent);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("[bilinear_image_scaler] OK");
    end else begin
      $display("[bilinear_image_scaler] ERROR");
    end
    $finish;
  end
endmodule
